// File: rtl/core/mfp_pkg.sv
// ----------------------------------------------------------------------------
// Metering frame parser package
// Shared widths, codes, record types and helper functions of the parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

    localparam int FRAME_BYTES    = 35;
    localparam int GAIN_FRAC_BITS = 16;

    localparam int POS_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 24;
    localparam int GAIN_W     = 24;
    localparam int VAL_W      = 32;
    localparam int PROD_W     = RAW_W + GAIN_W;
    localparam int CNT_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FIELD_LANES = RAW_W / BYTE_W;

    // Result data: four values, two flags and the count, padded to whole bytes.
    localparam int OUT_BITS   = 4 * VAL_W + 2 + CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [POS_W-1:0] FRAME_POS = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] CHECK_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CUR_POS   = POS_W'(4);
    localparam logic [POS_W-1:0] VOLT_POS  = POS_W'(10);
    localparam logic [POS_W-1:0] PWR_POS   = POS_W'(16);
    localparam logic [POS_W-1:0] ENGY_POS  = POS_W'(22);

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SEED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_V_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_E_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;

    localparam logic [BYTE_W-1:0] SEED_RESET   = 8'd88;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 24'd65536;
    localparam logic [CNT_W-1:0]  THRESH_RESET = 8'd3;
    localparam logic [CNT_W-1:0]  COUNT_MAX    = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] seed;
        logic [GAIN_W-1:0] v_gain;
        logic [GAIN_W-1:0] c_gain;
        logic [GAIN_W-1:0] p_gain;
        logic [GAIN_W-1:0] e_gain;
        logic [CNT_W-1:0]  threshold;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RAW_W-1:0]    voltage;
        logic [RAW_W-1:0]    current;
        logic [RAW_W-1:0]    power;
        logic [RAW_W-1:0]    energy;
        logic                fault_raised;
        logic                fault_cleared;
        logic [CNT_W-1:0]    error_count;
    } judged_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PROD_W-1:0]   voltage;
        logic [PROD_W-1:0]   current;
        logic [PROD_W-1:0]   power;
        logic [PROD_W-1:0]   energy;
        logic                fault_raised;
        logic                fault_cleared;
        logic [CNT_W-1:0]    error_count;
    } product_t;

    // Replace the byte lane of a little-endian field that the position selects.
    function automatic logic [RAW_W-1:0] put_byte(input logic [RAW_W-1:0]  field,
                                                  input logic [POS_W-1:0]  pos,
                                                  input logic [POS_W-1:0]  base,
                                                  input logic [BYTE_W-1:0] data);
        logic [RAW_W-1:0] res;
        res = field;
        for (int lane = 0; lane < FIELD_LANES; lane++)
        begin
            if (pos == base + POS_W'(lane))
            begin
                res[lane*BYTE_W +: BYTE_W] = data;
            end
        end
        return res;
    endfunction

    // Drop the fraction bits and clamp anything that does not fit the result.
    function automatic logic [VAL_W-1:0] scale_sat(input logic [PROD_W-1:0] prod);
        logic [PROD_W-1:0] shifted;
        shifted = prod >> GAIN_FRAC_BITS;
        if (|shifted[PROD_W-1:VAL_W])
        begin
            return {VAL_W{1'b1}};
        end
        return shifted[VAL_W-1:0];
    endfunction

endpackage

// File: rtl/core/mfp_frame.sv
// ----------------------------------------------------------------------------
// Frame tracker
// Follows the byte position, running sum and field capture of one frame,
// judges the frame or a timeout and keeps the consecutive error count.
// ----------------------------------------------------------------------------
module mfp_frame (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_accept,
    input  logic                        opcode,
    input  logic [mfp_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        frame_end,
    input  mfp_pkg::cfg_t               cfg,
    input  logic                        next_free,
    output logic                        rec_valid,
    output mfp_pkg::judged_t            rec
);
    import mfp_pkg::*;

    logic [POS_W-1:0]  pos_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] check_reg;
    logic [RAW_W-1:0]  raw_current_reg;
    logic [RAW_W-1:0]  raw_voltage_reg;
    logic [RAW_W-1:0]  raw_power_reg;
    logic [RAW_W-1:0]  raw_energy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              rec_valid_reg;
    judged_t           rec_reg;

    logic [POS_W-1:0]    pos_inc;
    logic [BYTE_W-1:0]   sum_add;
    logic [BYTE_W-1:0]   check_upd;
    logic [BYTE_W-1:0]   sum_seed;
    logic [RAW_W-1:0]    pw_mag;
    logic [CNT_W-1:0]    cnt_plus;
    logic                cnt_sat;
    logic                produces;
    logic [STATUS_W-1:0] status_next;
    logic                raised_next;
    logic                cleared_next;
    logic [CNT_W-1:0]    cnt_next;
    judged_t             rec_next;

    always_comb
    begin
        pos_inc   = (pos_reg < FRAME_POS) ? pos_reg + POS_W'(1) : pos_reg;
        sum_add   = (pos_reg < CHECK_POS) ? sum_reg + rx_byte : sum_reg;
        check_upd = (pos_reg == CHECK_POS) ? rx_byte : check_reg;
        sum_seed  = cfg.seed + sum_add;
        pw_mag    = raw_power_reg[RAW_W-1] ? (~raw_power_reg + RAW_W'(1)) : raw_power_reg;
        cnt_sat   = (cnt_reg == COUNT_MAX);
        cnt_plus  = cnt_reg + CNT_W'(1);
        produces  = (opcode == OP_TIMEOUT) || frame_end;
    end

    // Judgment: timeout first, then length, then checksum; every error bumps the count until it saturates.
    always_comb
    begin
        cleared_next = 1'b0;
        if (opcode == OP_TIMEOUT)
        begin
            status_next = ST_TIMEOUT;
        end
        else if (pos_inc < FRAME_POS)
        begin
            status_next = ST_SHORT;
        end
        else if (check_upd != ~sum_seed)
        begin
            status_next = ST_CHECKSUM;
        end
        else
        begin
            status_next = ST_OK;
        end

        if (status_next == ST_OK)
        begin
            raised_next  = 1'b0;
            cleared_next = (cnt_reg >= cfg.threshold);
            cnt_next     = '0;
        end
        else
        begin
            raised_next = !cnt_sat && (cnt_plus == cfg.threshold);
            cnt_next    = cnt_sat ? cnt_reg : cnt_plus;
        end

        rec_next.status        = status_next;
        rec_next.voltage       = raw_voltage_reg;
        rec_next.current       = raw_current_reg;
        rec_next.power         = pw_mag;
        rec_next.energy        = raw_energy_reg;
        rec_next.fault_raised  = raised_next;
        rec_next.fault_cleared = cleared_next;
        rec_next.error_count   = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            sum_reg         <= '0;
            check_reg       <= '0;
            raw_current_reg <= '0;
            raw_voltage_reg <= '0;
            raw_power_reg   <= '0;
            raw_energy_reg  <= '0;
            cnt_reg         <= '0;
            rec_valid_reg   <= 1'b0;
        end
        else
        begin
            if (item_accept)
            begin
                if (opcode == OP_BYTE)
                begin
                    check_reg       <= check_upd;
                    raw_current_reg <= put_byte(raw_current_reg, pos_reg, CUR_POS, rx_byte);
                    raw_voltage_reg <= put_byte(raw_voltage_reg, pos_reg, VOLT_POS, rx_byte);
                    raw_power_reg   <= put_byte(raw_power_reg, pos_reg, PWR_POS, rx_byte);
                    raw_energy_reg  <= put_byte(raw_energy_reg, pos_reg, ENGY_POS, rx_byte);
                end
                if (produces)
                begin
                    pos_reg <= '0;
                    sum_reg <= '0;
                    cnt_reg <= cnt_next;
                end
                else
                begin
                    pos_reg <= pos_inc;
                    sum_reg <= sum_add;
                end
            end

            if (item_accept && produces)
            begin
                rec_valid_reg <= 1'b1;
            end
            else if (next_free)
            begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && produces)
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

// File: rtl/core/mfp_scale.sv
// ----------------------------------------------------------------------------
// Gain multipliers
// Four parallel lanes, each one 24x24 unsigned multiply into a product register.
// ----------------------------------------------------------------------------
module mfp_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    input  mfp_pkg::judged_t   rec,
    input  mfp_pkg::cfg_t      cfg,
    input  logic               stage_free,
    output logic               prod_valid,
    output mfp_pkg::product_t  prod
);
    import mfp_pkg::*;

    logic     prod_valid_reg;
    product_t prod_reg;
    product_t prod_next;

    always_comb
    begin
        prod_next.status        = rec.status;
        prod_next.voltage       = PROD_W'(rec.voltage) * PROD_W'(cfg.v_gain);
        prod_next.current       = PROD_W'(rec.current) * PROD_W'(cfg.c_gain);
        prod_next.power         = PROD_W'(rec.power) * PROD_W'(cfg.p_gain);
        prod_next.energy        = PROD_W'(rec.energy) * PROD_W'(cfg.e_gain);
        prod_next.fault_raised  = rec.fault_raised;
        prod_next.fault_cleared = rec.fault_cleared;
        prod_next.error_count   = rec.error_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (stage_free)
        begin
            prod_valid_reg <= rec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_free && rec_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

// File: rtl/core/mfp_out.sv
// ----------------------------------------------------------------------------
// Result stage
// Truncates and clamps the products, holds the last good values and drives
// the result register of the output stream.
// ----------------------------------------------------------------------------
module mfp_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           prod_valid,
    input  mfp_pkg::product_t              prod,
    input  logic                           stage_free,
    output logic                           out_valid,
    output logic [mfp_pkg::OUT_DATA_W-1:0] out_data,
    output logic [mfp_pkg::STATUS_W-1:0]   out_status
);
    import mfp_pkg::*;

    logic [VAL_W-1:0]    voltage_reg;
    logic [VAL_W-1:0]    current_reg;
    logic [VAL_W-1:0]    power_reg;
    logic [VAL_W-1:0]    energy_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                raised_reg;
    logic                cleared_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                load;

    assign load = stage_free && prod_valid;

    // The scaled values are block state: only a good frame replaces them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_reg   <= '0;
            current_reg   <= '0;
            power_reg     <= '0;
            energy_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (stage_free)
            begin
                out_valid_reg <= prod_valid;
            end
            if (load && prod.status == ST_OK)
            begin
                voltage_reg <= scale_sat(prod.voltage);
                current_reg <= scale_sat(prod.current);
                power_reg   <= scale_sat(prod.power);
                energy_reg  <= scale_sat(prod.energy);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= prod.status;
            raised_reg  <= prod.fault_raised;
            cleared_reg <= prod.fault_cleared;
            count_reg   <= prod.error_count;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_data   = {(OUT_DATA_W - OUT_BITS)'(0), count_reg, cleared_reg, raised_reg,
                         energy_reg, power_reg, current_reg, voltage_reg};

endmodule

// File: rtl/core/meter_frame_parser_with_fault_count_core.sv
// ----------------------------------------------------------------------------
// Metering frame parser with fault counter
// Parses metering response frames byte by byte, checks length and checksum,
// scales the captured fields and tracks consecutive errors.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle while s_tready is high; each
// byte is folded into the frame state as it is accepted, and each gain lane
// has one 24x24 multiplier. A frame-end or timeout transaction passes the
// judge, multiply and result registers in turn before it reaches the output.
// Reset clears the frame state, scaled values, error count and all valid
// flags, and loads the configuration registers with their default values.
module meter_frame_parser_with_fault_count_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    input  logic                            s_tuser,   // [0] opcode
    input  logic                            s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] voltage, [63:32] current, [95:64] power, [127:96] energy,
    // [128] fault_raised, [129] fault_cleared, [137:130] error_count, rest zero
    output logic [mfp_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [mfp_pkg::STATUS_W-1:0]    m_tuser,   // [1:0] status
    input  logic                            cfg_we,
    input  logic [mfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mfp_pkg::*;

    cfg_t     cfg_reg;
    logic     rec_valid;
    judged_t  rec;
    logic     prod_valid;
    product_t prod;
    logic     o_free;
    logic     p_free;
    logic     j_free;
    logic     item_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed      <= SEED_RESET;
            cfg_reg.v_gain    <= GAIN_RESET;
            cfg_reg.c_gain    <= GAIN_RESET;
            cfg_reg.p_gain    <= GAIN_RESET;
            cfg_reg.e_gain    <= GAIN_RESET;
            cfg_reg.threshold <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEED:      cfg_reg.seed      <= cfg_data[BYTE_W-1:0];
                REG_V_GAIN:    cfg_reg.v_gain    <= cfg_data[GAIN_W-1:0];
                REG_C_GAIN:    cfg_reg.c_gain    <= cfg_data[GAIN_W-1:0];
                REG_P_GAIN:    cfg_reg.p_gain    <= cfg_data[GAIN_W-1:0];
                REG_E_GAIN:    cfg_reg.e_gain    <= cfg_data[GAIN_W-1:0];
                REG_THRESHOLD: cfg_reg.threshold <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // A stage may load when it is empty or its content moves on this cycle.
    assign o_free      = !m_tvalid || m_tready;
    assign p_free      = !prod_valid || o_free;
    assign j_free      = !rec_valid || p_free;
    assign s_tready    = j_free;
    assign item_accept = s_tvalid && s_tready;

    mfp_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (item_accept),
        .opcode      (s_tuser),
        .rx_byte     (s_tdata),
        .frame_end   (s_tlast),
        .cfg         (cfg_reg),
        .next_free   (p_free),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    mfp_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (rec_valid),
        .rec        (rec),
        .cfg        (cfg_reg),
        .stage_free (p_free),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    mfp_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .stage_free (o_free),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

    logic             out_raised;
    logic             out_cleared;
    logic [CNT_W-1:0] out_count;

    assign out_raised  = m_tdata[4*VAL_W];
    assign out_cleared = m_tdata[4*VAL_W+1];
    assign out_count   = m_tdata[4*VAL_W+2 +: CNT_W];

    // Input is only held off when a finished result is waiting downstream.
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_ok_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_OK) |-> (out_count == '0 && !out_raised))
        else $error("good frame did not clear the error count");

    a_error_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (out_count != '0 && !out_cleared))
        else $error("error result without a counted error");

    a_raise_at_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_raised) |-> (out_count == cfg_reg.threshold))
        else $error("fault raised away from the threshold");

endmodule
